// ----- rtl/core/crsf_div_pkg.sv -----
// Shared types and constants for the receiver diversity frame switch.
// Request and result structs, request and destination codes, frame constants.
// No dependencies.
package crsf_div_pkg;

    typedef enum logic [1:0] {
        REQ_PRIMARY   = 2'd0,
        REQ_SECONDARY = 2'd1,
        REQ_FC        = 2'd2,
        REQ_TICK      = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        DEST_FC        = 2'd0,
        DEST_PRIMARY   = 2'd1,
        DEST_SECONDARY = 2'd2,
        DEST_UNUSED    = 2'd3
    } t_dest;

    typedef enum logic [1:0] {
        CFG_TIMEOUT     = 2'd0,
        CFG_THRESHOLD   = 2'd1,
        CFG_AUTO_SWITCH = 2'd2,
        CFG_NONE        = 2'd3
    } t_cfg_index;

    typedef struct packed {
        t_req_type   req_type;
        logic [7:0]  data_byte;
    } t_req;

    typedef struct packed {
        logic        fwd_valid;
        t_dest       fwd_dest;
        logic [7:0]  fwd_byte;
        logic        frame_ok;
        logic        active_rx;
        logic [7:0]  quality_primary;
        logic [7:0]  quality_secondary;
    } t_rsp;

    typedef struct packed {
        logic        frame_ok;
        logic        rc_ok;
        logic [10:0] chan_value;
        logic [7:0]  link_quality;
    } t_trk_status;

    localparam logic [7:0]  SYNC_BYTE       = 8'hC8;
    localparam logic [7:0]  KIND_RC         = 8'h16;
    localparam logic [7:0]  KIND_LINK       = 8'h14;
    localparam logic [7:0]  RC_MIN_LENGTH   = 8'd24;
    localparam logic [7:0]  LINK_MIN_LENGTH = 8'd8;
    localparam int          MIN_LENGTH      = 3;
    localparam int          POS_KIND        = 2;
    localparam int          POS_QUALITY     = 5;
    localparam int          POS_CHAN_LOW    = 12;
    localparam int          POS_CHAN_HIGH   = 13;
    localparam int          LEN_CMP_W       = 10;

    localparam logic [15:0] TIMEOUT_RESET   = 16'd500;
    localparam logic [10:0] THRESHOLD_RESET = 11'd1500;

endpackage

// ----- rtl/core/crsf_diversity_frame_switch_core.sv -----
// Top level of the receiver diversity frame switch.
// Depends on crsf_div_pkg and crsf_div_tracker (one per receiver).
// Usage:
//   Request channel (i_in_valid / o_in_stall / i_in_req) carries one byte from
//   the primary receiver, the secondary receiver or the flight controller, or
//   a millisecond tick. Each request yields exactly one result on the result
//   channel (o_out_valid / i_out_stall / o_out_rsp): the forwarded byte and its
//   destination, the frame-accepted flag, the active receiver after the
//   request, and both link quality values.
//   Configuration writes use i_cfg_valid / o_cfg_ready (always ready) with a
//   register index and data; write only while no request is in flight.
// Path: a taken request is held in the request register, processed by the
//   combinational logic, and its result is captured in the result register.
// Throughput: one request per cycle while the result is not stalled; the
//   request register and the result register form a two-stage pipe, and all
//   tracking and selection logic is a single combinational pass between them.
// Reset: frame trackers, ages, qualities and the channel-8 value clear, the
//   primary receiver is active, timeout 500, threshold 1500, failover on.
// Stall: while the result waits, one more request is taken into the request
//   register; beyond that o_in_stall holds the request side.
module crsf_diversity_frame_switch_core
    import crsf_div_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 64,
    parameter int AGE_BITS        = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_req        i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_rsp        o_out_rsp,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  t_cfg_index  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int CMP_W = (AGE_BITS > 16) ? AGE_BITS : 16;

    logic          r_in_valid;
    t_req          r_in;
    logic          r_out_valid;
    t_rsp          r_out, n_out;
    logic [10:0]   r_switch, n_switch;
    logic          r_active, n_active;
    logic [15:0]   r_timeout;
    logic [10:0]   r_threshold;
    logic          r_auto;

    logic          w_adv;
    logic          w_in_acc;
    t_trk_status   w_stat [2];
    logic [AGE_BITS-1:0] w_age [2];
    logic          w_byte_en [2];
    logic          w_tick;
    logic          w_lost;
    logic          w_manual;
    logic          w_other;
    logic [CMP_W-1:0] w_timeout_ext;

    assign w_adv       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_adv;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign w_byte_en[0] = r_in.req_type == REQ_PRIMARY;
    assign w_byte_en[1] = r_in.req_type == REQ_SECONDARY;
    assign w_tick       = r_in.req_type == REQ_TICK;

    for (genvar g = 0; g < 2; g++) begin : g_rx
        crsf_div_tracker #(
            .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
            .AGE_BITS        (AGE_BITS)
        ) u_tracker (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (w_adv),
            .i_byte_en  (w_byte_en[g]),
            .i_tick     (w_tick),
            .i_byte     (r_in.data_byte),
            .o_status   (w_stat[g]),
            .o_age_next (w_age[g])
        );
    end

    assign w_timeout_ext = CMP_W'(r_timeout);

    always_comb begin
        priority if (w_stat[0].rc_ok) begin
            n_switch = w_stat[0].chan_value;
        end else if (w_stat[1].rc_ok) begin
            n_switch = w_stat[1].chan_value;
        end else begin
            n_switch = r_switch;
        end
    end

    always_comb begin
        w_lost   = CMP_W'(w_age[r_active]) > w_timeout_ext;
        w_manual = (n_switch != 11'd0) ? (n_switch > r_threshold) : r_active;
        w_other  = ~w_manual;
        n_active = w_manual;
        if (r_auto && w_lost && (CMP_W'(w_age[w_other]) < w_timeout_ext)) begin
            n_active = w_other;
        end
    end

    always_comb begin
        n_out.fwd_valid = 1'b0;
        n_out.fwd_dest  = DEST_FC;
        n_out.fwd_byte  = 8'd0;
        unique case (r_in.req_type)
            REQ_PRIMARY, REQ_SECONDARY: begin
                if (r_in.req_type[0] == r_active) begin
                    n_out.fwd_valid = 1'b1;
                    n_out.fwd_byte  = r_in.data_byte;
                end
            end
            REQ_FC: begin
                n_out.fwd_valid = 1'b1;
                n_out.fwd_dest  = r_active ? DEST_SECONDARY : DEST_PRIMARY;
                n_out.fwd_byte  = r_in.data_byte;
            end
            REQ_TICK: begin
            end
            default: begin
            end
        endcase
        n_out.frame_ok          = w_stat[0].frame_ok | w_stat[1].frame_ok;
        n_out.active_rx         = n_active;
        n_out.quality_primary   = w_stat[0].link_quality;
        n_out.quality_secondary = w_stat[1].link_quality;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_switch    <= '0;
            r_active    <= 1'b0;
            r_timeout   <= TIMEOUT_RESET;
            r_threshold <= THRESHOLD_RESET;
            r_auto      <= 1'b1;
        end else begin
            if (w_in_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_switch    <= n_switch;
                r_active    <= n_active;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_TIMEOUT:     r_timeout   <= i_cfg_data;
                    CFG_THRESHOLD:   r_threshold <= i_cfg_data[10:0];
                    CFG_AUTO_SWITCH: r_auto      <= i_cfg_data[0];
                    CFG_NONE: begin
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in_req;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

`ifndef SYNTHESIS
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in)))
        else $error("pending request lost while result stalled");
    a_active_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_active))
        else $error("active receiver changed without a request");
    a_ok_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.frame_ok) |-> (o_out_rsp.fwd_dest == DEST_FC))
        else $error("accepted frame on a flight controller request");
    a_no_fwd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_rsp.fwd_valid)
            |-> (o_out_rsp.fwd_byte == 8'd0 && o_out_rsp.fwd_dest == DEST_FC))
        else $error("idle forward fields not cleared");
    a_result_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (o_out_rsp.active_rx == r_active))
        else $error("result active receiver differs from state");
`endif

endmodule

// ----- rtl/core/crsf_div_tracker.sv -----
// Frame tracker, age counter and link quality of one receiver.
// Depends on crsf_div_pkg for frame constants and the status struct.
// Updates state on each advance of the request stage.
module crsf_div_tracker
    import crsf_div_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 64,
    parameter int AGE_BITS        = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_byte_en,
    input  logic                i_tick,
    input  logic [7:0]          i_byte,
    output t_trk_status         o_status,
    output logic [AGE_BITS-1:0] o_age_next
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 3);

    logic [POS_W-1:0]    r_pos, n_pos;
    logic [7:0]          r_len, n_len;
    logic [7:0]          r_kind, n_kind;
    logic [7:0]          r_qual, n_qual;
    logic [7:0]          r_chan_low, n_chan_low;
    logic [7:0]          r_chan_high, n_chan_high;
    logic [AGE_BITS-1:0] r_age, n_age;
    logic [7:0]          r_link, n_link;

    logic [POS_W-1:0]    w_pos_inc;
    logic                w_bad_len;
    logic                w_done;
    logic                w_rc_ok;
    logic                w_link_ok;

    assign w_pos_inc = r_pos + POS_W'(1);
    assign w_bad_len = (LEN_CMP_W'(i_byte) < LEN_CMP_W'(MIN_LENGTH))
                    || (LEN_CMP_W'(i_byte) > LEN_CMP_W'(MAX_FRAME_BYTES));

    always_comb begin
        n_pos       = r_pos;
        n_len       = r_len;
        n_kind      = r_kind;
        n_qual      = r_qual;
        n_chan_low  = r_chan_low;
        n_chan_high = r_chan_high;
        n_age       = r_age;
        n_link      = r_link;
        w_done      = 1'b0;
        w_rc_ok     = 1'b0;
        w_link_ok   = 1'b0;
        if (i_byte_en) begin
            if (r_pos == POS_W'(0)) begin
                if (i_byte == SYNC_BYTE) begin
                    n_pos = POS_W'(1);
                end
            end else if (r_pos == POS_W'(1)) begin
                n_len = i_byte;
                n_pos = w_bad_len ? POS_W'(0) : POS_W'(2);
            end else begin
                if (r_pos == POS_W'(POS_KIND))      n_kind      = i_byte;
                if (r_pos == POS_W'(POS_QUALITY))   n_qual      = i_byte;
                if (r_pos == POS_W'(POS_CHAN_LOW))  n_chan_low  = i_byte;
                if (r_pos == POS_W'(POS_CHAN_HIGH)) n_chan_high = i_byte;
                if (LEN_CMP_W'(w_pos_inc) < (LEN_CMP_W'(r_len) + LEN_CMP_W'(2))) begin
                    n_pos = w_pos_inc;
                end else begin
                    n_pos  = POS_W'(0);
                    w_done = 1'b1;
                end
            end
            if (w_done) begin
                if (n_kind == KIND_RC && r_len >= RC_MIN_LENGTH) begin
                    w_rc_ok = 1'b1;
                    n_age   = '0;
                end else if (n_kind == KIND_LINK && r_len >= LINK_MIN_LENGTH) begin
                    w_link_ok = 1'b1;
                    n_link    = n_qual;
                    n_age     = '0;
                end
            end
        end else if (i_tick) begin
            if (r_age != {AGE_BITS{1'b1}}) begin
                n_age = r_age + AGE_BITS'(1);
            end
        end
    end

    assign o_status.frame_ok     = w_rc_ok | w_link_ok;
    assign o_status.rc_ok        = w_rc_ok;
    assign o_status.chan_value   = {n_chan_high, n_chan_low[7:5]};
    assign o_status.link_quality = n_link;
    assign o_age_next            = n_age;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_len       <= '0;
            r_kind      <= '0;
            r_qual      <= '0;
            r_chan_low  <= '0;
            r_chan_high <= '0;
            r_age       <= '0;
            r_link      <= '0;
        end else if (i_adv) begin
            r_pos       <= n_pos;
            r_len       <= n_len;
            r_kind      <= n_kind;
            r_qual      <= n_qual;
            r_chan_low  <= n_chan_low;
            r_chan_high <= n_chan_high;
            r_age       <= n_age;
            r_link      <= n_link;
        end
    end

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LEN_CMP_W'(r_pos) <= LEN_CMP_W'(MAX_FRAME_BYTES + 1))
        else $error("frame position beyond longest frame");
    a_len_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos >= POS_W'(2)) |-> (LEN_CMP_W'(r_len) >= LEN_CMP_W'(MIN_LENGTH)
            && LEN_CMP_W'(r_len) <= LEN_CMP_W'(MAX_FRAME_BYTES)))
        else $error("frame in progress with illegal length");
    a_pos_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos >= POS_W'(2)) |-> (LEN_CMP_W'(r_pos) <= LEN_CMP_W'(r_len) + LEN_CMP_W'(1)))
        else $error("frame position past frame end");
    a_ok_clears_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_status.frame_ok) |=> (r_age == '0))
        else $error("accepted frame did not clear age");
`endif

endmodule
